// ----- rtl/isl_pkg.sv -----
package isl_pkg;

  // Field widths of the word formats.
  localparam int FUNC_W   = 3;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 7;

  // Number of cells in the chain; the count field must be able to hold it.
  localparam int CAPACITY = 64;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT     = 3'd0,
    FN_APPEND     = 3'd1,
    FN_REMOVE     = 3'd2,
    FN_REMOVE_END = 3'd3,
    FN_READ       = 3'd4,
    FN_CONTAINS   = 3'd5
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // Command broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic             exec;
    logic             load;
    logic             shift_up;
    logic             shift_down;
    logic             read_en;
    logic             search_en;
    logic [POS_W-1:0] pos;
    logic [CNT_W-1:0] limit;
    data_t            value;
  } cell_cmd_t;

endpackage

// ----- rtl/isl_if.sv -----
interface isl_in_if;
  import isl_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  data_t             item_value;
  logic [POS_W-1:0]  position;

  modport source (output valid, output func, output item_value, output position, input ready);
  modport sink   (input valid, input func, input item_value, input position, output ready);
endinterface

interface isl_out_if;
  import isl_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  data_t               read_value;
  logic                found;
  logic [CNT_W-1:0]    count;
  logic                is_empty;

  modport source (output valid, output status, output read_value, output found,
                  output count, output is_empty, input ready);
  modport sink   (input valid, input status, input read_value, input found,
                  input count, input is_empty, output ready);
endinterface

// ----- rtl/isl_cell.sv -----
module isl_cell (
  input  logic                     clk,
  input  isl_pkg::cell_cmd_t       cmd,
  input  logic [isl_pkg::POS_W-1:0] idx,
  input  isl_pkg::data_t           left_data,
  input  isl_pkg::data_t           right_data,
  output isl_pkg::data_t           entry,
  output logic                     hit,
  output isl_pkg::data_t           rd_data
);
  import isl_pkg::*;

  data_t entry_r, entry_nxt;
  data_t rd_r, rd_nxt;
  logic  hit_r, hit_nxt;

  always_comb begin
    entry_nxt = entry_r;
    rd_nxt    = rd_r;
    hit_nxt   = hit_r;
    if (cmd.exec) begin
      if (cmd.load && (idx == cmd.pos)) begin
        entry_nxt = cmd.value;
      end else if (cmd.shift_up && (idx > cmd.pos)) begin
        entry_nxt = left_data;
      end else if (cmd.shift_down && (idx >= cmd.pos)) begin
        entry_nxt = right_data;
      end
      // Tags are taken from the entry as it stood before this command.
      hit_nxt = cmd.search_en && (CNT_W'(idx) < cmd.limit) && (entry_r == cmd.value);
      rd_nxt  = (cmd.read_en && (idx == cmd.pos)) ? entry_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    rd_r    <= rd_nxt;
    hit_r   <= hit_nxt;
  end

  assign entry   = entry_r;
  assign hit     = hit_r;
  assign rd_data = rd_r;

endmodule

// ----- rtl/indexed_shift_list.sv -----
// Channel  Direction  Handshake          Word contents
// in_ch    sink       valid / ready      func, item_value, position
// out_ch   source     valid / ready      status, read_value, found, count, is_empty
//
// A word goes through S_IDLE, S_EXEC and S_DONE: S_IDLE accepts it, decodes
// the request and updates the fill count, S_EXEC lets every cell shift, load
// or compare at once, and S_DONE gathers the cell tags into the output
// register. Reset (rst_n low, synchronous) clears the fill count and the
// control state; the cell contents stay undefined until written. A stalled
// result waits in the output register while the next word is taken.
module indexed_shift_list (
  input logic      clk,
  input logic      rst_n,
  isl_in_if.sink   in_ch,
  isl_out_if.source out_ch
);
  import isl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  cell_cmd_t        cmd_r, cmd_nxt;
  status_t          res_status_r, res_status_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  data_t               out_value_r, out_value_nxt;
  logic                out_found_r, out_found_nxt;
  logic [CNT_W-1:0]    out_count_r, out_count_nxt;
  logic                out_empty_r, out_empty_nxt;

  // Cell chain wiring.
  cell_cmd_t                      cell_cmd;
  data_t                          cell_entry [CAPACITY];
  data_t                          cell_rd    [CAPACITY];
  logic [CAPACITY-1:0]            hit_vec;
  logic [DATA_W-1:0][CAPACITY-1:0] rd_mat;
  data_t                          rd_or;

  // The command reaches the cells only during the execute cycle.
  always_comb begin
    cell_cmd      = cmd_r;
    cell_cmd.exec = (state_r == S_EXEC);
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    data_t left_d, right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_entry[i];
    end else begin : g_mid_r
      assign right_d = cell_entry[i+1];
    end

    isl_cell u_cell (
      .clk        (clk),
      .cmd        (cell_cmd),
      .idx        (POS_W'(i)),
      .left_data  (left_d),
      .right_data (right_d),
      .entry      (cell_entry[i]),
      .hit        (hit_vec[i]),
      .rd_data    (cell_rd[i])
    );

    for (genvar b = 0; b < DATA_W; b++) begin : g_bit
      assign rd_mat[b][i] = cell_rd[i][b];
    end
  end

  // At most one cell holds a nonzero read tag, so an OR gathers the value.
  for (genvar b = 0; b < DATA_W; b++) begin : g_rd_or
    assign rd_or[b] = |rd_mat[b];
  end

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    cmd_nxt        = cmd_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    out_empty_nxt  = out_empty_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          // Decode against the fill count before this word.
          cmd_nxt            = '0;
          cmd_nxt.pos        = in_ch.position;
          cmd_nxt.limit      = fill_r;
          cmd_nxt.value      = in_ch.item_value;
          res_status_nxt     = ST_OK;
          case (func_t'(in_ch.func))
            FN_INSERT: begin
              if (CNT_W'(in_ch.position) > fill_r) begin
                res_status_nxt = ST_RANGE;
              end else if (fill_r >= CNT_W'(CAPACITY)) begin
                res_status_nxt = ST_FULL;
              end else begin
                cmd_nxt.load     = 1'b1;
                cmd_nxt.shift_up = 1'b1;
                fill_nxt         = fill_r + 1'b1;
              end
            end
            FN_APPEND: begin
              if (fill_r >= CNT_W'(CAPACITY)) begin
                res_status_nxt = ST_FULL;
              end else begin
                cmd_nxt.load = 1'b1;
                cmd_nxt.pos  = POS_W'(fill_r);
                fill_nxt     = fill_r + 1'b1;
              end
            end
            FN_REMOVE: begin
              if (CNT_W'(in_ch.position) >= fill_r) begin
                res_status_nxt = ST_RANGE;
              end else begin
                cmd_nxt.shift_down = 1'b1;
                fill_nxt           = fill_r - 1'b1;
              end
            end
            FN_REMOVE_END: begin
              if (fill_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                fill_nxt = fill_r - 1'b1;
              end
            end
            FN_READ: begin
              if (CNT_W'(in_ch.position) >= fill_r) begin
                res_status_nxt = ST_RANGE;
              end else begin
                cmd_nxt.read_en = 1'b1;
              end
            end
            FN_CONTAINS: begin
              cmd_nxt.search_en = 1'b1;
            end
            default: begin
              // Unused function codes leave the list alone.
            end
          endcase
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = rd_or;
          out_found_nxt  = |hit_vec;
          out_count_nxt  = fill_r;
          out_empty_nxt  = (fill_r == '0);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    res_status_r <= res_status_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.read_value = out_value_r;
  assign out_ch.found      = out_found_r;
  assign out_ch.count      = out_count_r;
  assign out_ch.is_empty   = out_empty_r;

  // The fill count never runs past the length of the chain.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(CAPACITY))
    else $error("fill count exceeds capacity");

  // An accepted word always moves the chain into its execute cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == S_EXEC))
    else $error("accepted word did not start execution");

  // A full status is reported only with a full list.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_FULL)) |-> (out_count_r == CNT_W'(CAPACITY)))
    else $error("full status with a list that is not full");

  // An empty status is reported only with an empty list.
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_EMPTY)) |-> (out_empty_r && (out_count_r == '0)))
    else $error("empty status with a list that is not empty");

endmodule

// ----- tb/sv/isl_tb_pkg.sv -----
`timescale 1ns / 100ps

package isl_tb_pkg;
  import isl_pkg::*;

  typedef struct {
    status_t          status;
    data_t            read_value;
    logic             found;
    logic [CNT_W-1:0] count;
    logic             is_empty;
  } list_result_t;

  // Mirror of the list contents. It also keeps the results owed by the block.
  class shift_list_mirror;
    data_t        cells[CAPACITY];
    int unsigned  fill;
    list_result_t owed[$];
    int unsigned  failures;

    function new();
      fill     = 0;
      failures = 0;
    endfunction

    // Applies one accepted request to the mirror and queues the result it owes.
    function void note_request(logic [FUNC_W-1:0] func, data_t value,
                               logic [POS_W-1:0] pos);
      list_result_t res;
      int unsigned  p;
      int unsigned  i;
      res.status     = ST_OK;
      res.read_value = '0;
      res.found      = 1'b0;
      p = pos;
      case (func)
        FN_INSERT: begin
          // The range test wins over the full test.
          if (p > fill) begin
            res.status = ST_RANGE;
          end else if (fill >= CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            for (i = fill; i > p; i--) cells[i] = cells[i-1];
            cells[p] = value;
            fill++;
          end
        end
        FN_APPEND: begin
          if (fill >= CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            cells[fill] = value;
            fill++;
          end
        end
        FN_REMOVE: begin
          if (p >= fill) begin
            res.status = ST_RANGE;
          end else begin
            for (i = p; i + 1 < fill; i++) cells[i] = cells[i+1];
            fill--;
          end
        end
        FN_REMOVE_END: begin
          if (fill == 0) res.status = ST_EMPTY;
          else fill--;
        end
        FN_READ: begin
          if (p >= fill) res.status = ST_RANGE;
          else res.read_value = cells[p];
        end
        FN_CONTAINS: begin
          for (i = 0; i < fill; i++) begin
            if (cells[i] == value) res.found = 1'b1;
          end
        end
        default: begin
        end
      endcase
      res.count    = CNT_W'(fill);
      res.is_empty = (fill == 0);
      owed.push_back(res);
    endfunction

    // Compares one delivered result with the oldest one owed.
    function void check_response(logic [STATUS_W-1:0] status, data_t read_value,
                                 logic found, logic [CNT_W-1:0] count,
                                 logic is_empty);
      list_result_t exp_res;
      if (owed.size() == 0) begin
        $error("result word arrived with none outstanding");
        failures++;
        return;
      end
      exp_res = owed.pop_front();
      if (status !== exp_res.status) begin
        $error("status: expected %0d, got %0d", exp_res.status, status);
        failures++;
      end
      if (read_value !== exp_res.read_value) begin
        $error("read_value: expected %0d, got %0d", exp_res.read_value, read_value);
        failures++;
      end
      if (found !== exp_res.found) begin
        $error("found: expected %0d, got %0d", exp_res.found, found);
        failures++;
      end
      if (count !== exp_res.count) begin
        $error("count: expected %0d, got %0d", exp_res.count, count);
        failures++;
      end
      if (is_empty !== exp_res.is_empty) begin
        $error("is_empty: expected %0d, got %0d", exp_res.is_empty, is_empty);
        failures++;
      end
    endfunction
  endclass

endpackage

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import isl_pkg::*;
  import isl_tb_pkg::*;

  // Codes 6 and 7 have no operation behind them; the block must ignore them.
  localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd7;

  localparam int RANDOM_WORDS = 1200;
  localparam int DRAIN_CYCLES = 20;
  // The slowest legal run is far below this: about 1250 words, each paying
  // its own pass through the block, the longest sender gap and the longest
  // receiver stall.
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum {PH_GROW, PH_MIXED, PH_SHRINK} phase_t;

  logic clk = 1'b0;
  logic rst_n;

  isl_in_if  in_ch();
  isl_out_if out_ch();

  indexed_shift_list u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  shift_list_mirror mirror = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sender. All inputs change on the falling edge, and a word counts as taken
  // only at a rising edge where valid and ready are both high. The sender runs
  // in bursts of random length; between bursts it idles for a random number of
  // cycles while the payload lines carry junk that the block must not take.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;

  // Presents one word and holds it until the block takes it. Returns at the
  // falling edge after acceptance, so the caller can present the next word.
  task automatic send_word(logic [FUNC_W-1:0] func, data_t value,
                           logic [POS_W-1:0] pos);
    in_ch.valid      <= 1'b1;
    in_ch.func       <= func;
    in_ch.item_value <= value;
    in_ch.position   <= pos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    mirror.note_request(func, value, pos);
    @(negedge clk);
  endtask

  // Drops valid for a number of cycles with scrambled payload lines.
  task automatic idle_gap(int unsigned cycles);
    in_ch.valid      <= 1'b0;
    in_ch.func       <= FUNC_W'($urandom);
    in_ch.item_value <= data_t'($urandom);
    in_ch.position   <= POS_W'($urandom);
    repeat (cycles) @(negedge clk);
  endtask

  // Sends one word inside the current burst, opening a new burst when the
  // last one is used up. Three in ten of the bursts start with no gap at all, and
  // now and then a long gap lets the block drain completely.
  task automatic send_paced(logic [FUNC_W-1:0] func, data_t value,
                            logic [POS_W-1:0] pos);
    int unsigned gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        3:       gap = $urandom_range(15, 30);
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap > 0) idle_gap(gap);
      burst_left = $urandom_range(1, 24);
    end
    send_word(func, value, pos);
    burst_left--;
  endtask

  // ---------------------------------------------------------------------------
  // Random word generation. The list only gets interesting when it is well
  // filled, so the random part runs in phases: growth phases push the list to
  // its capacity and keep knocking on it, shrink phases drain it to empty and
  // keep removing, and mixed phases wander in between.
  // ---------------------------------------------------------------------------
  function automatic logic [FUNC_W-1:0] pick_func(phase_t ph);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll >= 97) return $urandom_range(0, 1) ? FN_SPARE_A : FN_SPARE_B;
    case (ph)
      PH_GROW: begin
        if (roll < 36) return FN_INSERT;
        if (roll < 72) return FN_APPEND;
        if (roll < 80) return FN_READ;
        if (roll < 90) return FN_CONTAINS;
        if (roll < 94) return FN_REMOVE;
        return FN_REMOVE_END;
      end
      PH_SHRINK: begin
        if (roll < 36) return FN_REMOVE;
        if (roll < 66) return FN_REMOVE_END;
        if (roll < 76) return FN_READ;
        if (roll < 86) return FN_CONTAINS;
        if (roll < 91) return FN_INSERT;
        return FN_APPEND;
      end
      default: begin
        if (roll < 18) return FN_INSERT;
        if (roll < 36) return FN_APPEND;
        if (roll < 52) return FN_REMOVE;
        if (roll < 64) return FN_REMOVE_END;
        if (roll < 80) return FN_READ;
        return FN_CONTAINS;
      end
    endcase
  endfunction

  // Values lean on the extremes and on a small set of repeats, so that
  // duplicates sit in the list and searches can hit more than one entry.
  function automatic data_t pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      4, 5:    return data_t'($urandom_range(0, 7));
      default: return data_t'($urandom);
    endcase
  endfunction

  // Mostly legal indexes for the current fill; sometimes any 7-bit index.
  function automatic logic [POS_W-1:0] pick_position(logic [FUNC_W-1:0] func);
    int unsigned lim;
    lim = mirror.fill;
    if ($urandom_range(0, 99) < 12) return POS_W'($urandom_range(0, 127));
    if (func == FN_INSERT) return POS_W'($urandom_range(0, lim));
    if (lim == 0) return POS_W'($urandom_range(0, 127));
    return POS_W'($urandom_range(0, lim - 1));
  endfunction

  task automatic send_random(phase_t ph);
    logic [FUNC_W-1:0] func;
    data_t             value;
    func = pick_func(ph);
    // On a nonempty list, half the searches look for a value known to be in it.
    if (func == FN_CONTAINS && mirror.fill > 0 && $urandom_range(0, 1))
      value = mirror.cells[$urandom_range(0, mirror.fill - 1)];
    else
      value = pick_value();
    send_paced(func, value, pick_position(func));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver. Ready changes on the falling edge and follows a randomly redrawn
  // mode: always ready, coin toss, one cycle in four, or mostly ready with
  // occasional long stalls.
  // ---------------------------------------------------------------------------
  int unsigned rx_tick    = 0;
  int unsigned rx_mode    = 0;
  int unsigned stall_left = 0;

  always @(negedge clk) begin
    rx_tick++;
    if (rx_tick % 150 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= 1'($urandom_range(0, 1));
      2: out_ch.ready <= (rx_tick % 4 == 0);
      default: begin
        if (stall_left > 0) begin
          out_ch.ready <= 1'b0;
          stall_left--;
        end else begin
          out_ch.ready <= 1'b1;
          if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(5, 25);
        end
      end
    endcase
  end

  // Every result taken at a rising edge is checked against the mirror.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      mirror.check_response(out_ch.status, out_ch.read_value, out_ch.found,
                            out_ch.count, out_ch.is_empty);
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, a directed walk through the corner cases, the random
  // phases, then a drain until every owed result has been delivered.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned sent;
    int unsigned ph_idx;
    int unsigned len;
    phase_t      ph;

    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.func       = '0;
    in_ch.item_value = '0;
    in_ch.position   = '0;
    out_ch.ready     = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Everything that can go wrong on an empty list.
    send_paced(FN_REMOVE_END, 32'sd5, 7'd0);
    send_paced(FN_READ, 32'sd0, 7'd0);
    send_paced(FN_REMOVE, 32'sd0, 7'd0);
    send_paced(FN_CONTAINS, 32'sd0, 7'd0);
    // Insert one past the end is out of range even on an empty list.
    send_paced(FN_INSERT, 32'sd9, 7'd1);
    // Build [min, -1, max, 0] by inserting at the front, the middle and the end.
    send_paced(FN_INSERT, 32'h8000_0000, 7'd0);
    send_paced(FN_APPEND, 32'h7fff_ffff, 7'd0);
    send_paced(FN_INSERT, -32'sd1, 7'd1);
    send_paced(FN_INSERT, 32'sd0, 7'd3);
    send_paced(FN_READ, 32'sd0, 7'd0);
    send_paced(FN_READ, 32'sd0, 7'd1);
    send_paced(FN_READ, 32'sd0, 7'd2);
    send_paced(FN_READ, 32'sd0, 7'd3);
    // Reads at and far past the end.
    send_paced(FN_READ, 32'sd0, 7'd4);
    send_paced(FN_READ, 32'sd0, 7'd127);
    send_paced(FN_CONTAINS, 32'h7fff_ffff, 7'd0);
    send_paced(FN_CONTAINS, 32'sd12345, 7'd0);
    // The unused codes must leave the list alone and still answer.
    send_paced(FN_SPARE_A, -32'sd1, 7'd127);
    send_paced(FN_SPARE_B, 32'h8000_0000, 7'd0);
    send_paced(FN_REMOVE, 32'sd0, 7'd1);
    send_paced(FN_REMOVE, 32'sd0, 7'd127);
    send_paced(FN_INSERT, 32'sd7, 7'd127);
    send_paced(FN_REMOVE_END, 32'sd0, 7'd0);
    send_paced(FN_CONTAINS, -32'sd1, 7'd0);

    // Random phases in the order grow, mixed, shrink, mixed. Phase lengths
    // are long enough for a growth phase to reach the capacity and then keep
    // hitting the full status, and for a shrink phase to hit the empty one.
    // The last phase is cut short so the random part sends exactly its share.
    sent   = 0;
    ph_idx = 0;
    while (sent < RANDOM_WORDS) begin
      case (ph_idx % 4)
        0:       ph = PH_GROW;
        2:       ph = PH_SHRINK;
        default: ph = PH_MIXED;
      endcase
      len = $urandom_range(80, 200);
      if (len > RANDOM_WORDS - sent) len = RANDOM_WORDS - sent;
      repeat (len) begin
        send_random(ph);
        sent++;
      end
      ph_idx++;
    end

    in_ch.valid <= 1'b0;
    while (mirror.owed.size() != 0) @(posedge clk);
    // Keep running for DRAIN_CYCLES to expose any stray result.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/isl_pkg.sv
rtl/isl_if.sv
rtl/isl_cell.sv
rtl/indexed_shift_list.sv
tb/sv/isl_tb_pkg.sv
tb/sv/tb.sv
